// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file dit_checker.sv.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define DIT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("dit assertion failed");

// Check that a condition is followed by a consequence in the next cycle.
`define DIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dit assertion failed");

`endif

// ----- hw/rtl/dit_pkg.sv -----
// Package for the intern table: sizes, mode codes, request and response types.
// Depends on nothing.
package dit_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int ENTRY_BITS  = 64;
	localparam int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
	localparam int RIDX_CMP_BITS = (CNT_BITS > 8) ? CNT_BITS : 8;

	localparam logic [1:0] MODE_INTERN = 2'd0;
	localparam logic [1:0] MODE_READ   = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [63:0] entry_value;
		logic [7:0]  read_index;
	} req_t;

	typedef struct packed {
		logic [3:0]  slot_index;
		logic        was_present;
		logic        table_full;
		logic [63:0] read_value;
		logic        read_in_range;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ,
		ST_RESP
	} state_t;

	function automatic logic [3:0] to_slot(input logic [IDX_BITS-1:0] idx);
		logic [IDX_BITS+3:0] ext;
		ext = {4'd0, idx};
		return ext[3:0];
	endfunction

endpackage

// ----- hw/rtl/dit_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module dit_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/dedup_intern_table.sv -----
// Top level of the deduplicating intern table: sequencer, entry count, output register.
// Depends on dit_pkg and dit_ram.
//
// channel | signals                       | moves
// --------+-------------------------------+------------------------------
// req     | req_valid, req_ready, req     | one intern/read/clear request
// rsp     | rsp_valid, rsp_ready, rsp     | one result per request
//
// An intern compares the stored entries in slot order and ends at the first match or,
// on a miss, after the last entry; the single RAM read port scans one slot per cycle.
// A read passes through ST_READ; clear and unused mode go straight to ST_RESP.
// The next request is taken once the result has moved into the output register,
// even while that register still waits for rsp_ready.
// Reset empties the table at once; entry contents are not cleared.
module dedup_intern_table (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  dit_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output dit_pkg::rsp_t rsp
);
	import dit_pkg::*;

	state_t                state_q, state_d;
	logic [CNT_BITS-1:0]   count_q, count_d;
	logic [CNT_BITS-1:0]   scan_q, scan_d;
	logic                  pend_q, pend_d;
	logic [IDX_BITS-1:0]   cmp_idx_q, cmp_idx_d;
	logic [ENTRY_BITS-1:0] word_q, word_d;
	logic                  rd_ok_q, rd_ok_d;
	rsp_t                  res_q, res_d;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;
	logic                  load;

	logic                  ram_we;
	logic [IDX_BITS-1:0]   ram_waddr;
	logic                  ram_re;
	logic [IDX_BITS-1:0]   ram_raddr;
	logic [ENTRY_BITS-1:0] ram_rdata;

	dit_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(word_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		scan_d    = scan_q;
		pend_d    = 1'b0;
		cmp_idx_d = cmp_idx_q;
		word_d    = word_q;
		rd_ok_d   = rd_ok_q;
		res_d     = res_q;
		ram_we    = 1'b0;
		ram_waddr = count_q[IDX_BITS-1:0];
		ram_re    = 1'b0;
		ram_raddr = scan_q[IDX_BITS-1:0];
		load      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					res_d = '0;
					unique case (req.mode)
						MODE_INTERN: begin
							word_d  = req.entry_value[ENTRY_BITS-1:0];
							scan_d  = '0;
							state_d = ST_SCAN;
						end
						MODE_READ: begin
							rd_ok_d   = RIDX_CMP_BITS'(req.read_index) <
								RIDX_CMP_BITS'(count_q);
							ram_re    = rd_ok_d;
							ram_raddr = IDX_BITS'(req.read_index);
							state_d   = ST_READ;
						end
						MODE_CLEAR: begin
							count_d = '0;
							state_d = ST_RESP;
						end
						default: begin
							state_d = ST_RESP;
						end
					endcase
				end
			end
			ST_SCAN: begin
				priority if (pend_q && ram_rdata == word_q) begin
					res_d.slot_index  = to_slot(cmp_idx_q);
					res_d.was_present = 1'b1;
					state_d           = ST_RESP;
				end else if (scan_q < count_q) begin
					ram_re    = 1'b1;
					pend_d    = 1'b1;
					cmp_idx_d = scan_q[IDX_BITS-1:0];
					scan_d    = scan_q + 1'b1;
				end else if (!pend_q) begin
					if (count_q == CNT_BITS'(TABLE_DEPTH)) begin
						res_d.table_full = 1'b1;
					end else begin
						ram_we           = 1'b1;
						res_d.slot_index = to_slot(count_q[IDX_BITS-1:0]);
						count_d          = count_q + 1'b1;
					end
					state_d = ST_RESP;
				end else begin
					pend_d = 1'b0;
				end
			end
			ST_READ: begin
				if (rd_ok_q) begin
					res_d.read_value    = 64'(ram_rdata);
					res_d.read_in_range = 1'b1;
				end
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			scan_q      <= scan_d;
			pend_q      <= pend_d;
			rsp_valid_q <= load | (rsp_valid_q & ~rsp_ready);
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_q <= cmp_idx_d;
		word_q    <= word_d;
		rd_ok_q   <= rd_ok_d;
		res_q     <= res_d;
		if (load) begin
			rsp_q <= res_q;
		end
	end

endmodule

// ----- hw/rtl/dit_checker.sv -----
// Port-level checker for the intern table, bound to the top level.
// Depends on dit_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dit_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input dit_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input dit_pkg::rsp_t rsp
);
	import dit_pkg::*;

	`DIT_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
	`DIT_ASSERT_NEXT(a_busy_after_req, clk, arst_n, req_valid && req_ready, !req_ready)
	`DIT_ASSERT(a_full_fields, clk, arst_n, rsp_valid && rsp.table_full |-> rsp.slot_index == 4'd0 && !rsp.was_present && rsp.read_value == 64'd0)
	`DIT_ASSERT(a_intern_no_read, clk, arst_n, rsp_valid && (rsp.was_present || rsp.table_full) |-> !rsp.read_in_range && rsp.read_value == 64'd0)

endmodule

bind dedup_intern_table dit_checker u_dit_checker (.*);

// ----- dv/tb_dedup_intern_table.sv -----
`timescale 1ns / 100ps
// Testbench for dedup_intern_table: directed and random intern, read, clear and unused-mode requests,
// each response checked against an in-bench model of the table. Depends on dit_pkg and the RTL.
module tb_dedup_intern_table;
	import dit_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PCT    = 35;
	localparam int TAIL_CYCLES = 40;
	localparam int POOL_WORDS  = 24;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	logic [ENTRY_BITS-1:0] table_words [TABLE_DEPTH];
	int   table_fill;
	rsp_t answers_due [$];

	int  mismatches;
	int  requests_sent;
	int  responses_seen;
	int  hits;
	int  refusals;
	int  reads_out;
	int  cycles;
	bit  steady;

	dedup_intern_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic rsp_t table_answer(req_t r);
		rsp_t a;
		logic [ENTRY_BITS-1:0] word;
		bit found;
		a = '0;
		word = r.entry_value[ENTRY_BITS-1:0];
		found = 1'b0;
		case (r.mode)
		MODE_INTERN: begin
			for (int i = 0; i < table_fill && !found; i++) begin
				if (table_words[i] == word) begin
					a.slot_index = 4'(i);
					a.was_present = 1'b1;
					found = 1'b1;
				end
			end
			if (!found) begin
				if (table_fill >= TABLE_DEPTH) begin
					a.table_full = 1'b1;
				end else begin
					table_words[table_fill] = word;
					a.slot_index = 4'(table_fill);
					table_fill++;
				end
			end
		end
		MODE_READ: begin
			if (int'(r.read_index) < table_fill) begin
				a.read_value = 64'(table_words[r.read_index]);
				a.read_in_range = 1'b1;
			end
		end
		MODE_CLEAR: begin
			table_fill = 0;
		end
		default: ;
		endcase
		return a;
	endfunction

	function automatic req_t make_req(logic [1:0] mode, logic [63:0] value, logic [7:0] index);
		req_t r;
		r.mode = mode;
		r.entry_value = value;
		r.read_index = index;
		return r;
	endfunction

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	task automatic send_request(req_t r);
		rsp_t a;
		int gap;
		gap = 0;
		if (!steady && $urandom_range(99) < IDLE_PCT)
			gap = $urandom_range(1, 6);
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		a = table_answer(r);
		answers_due.push_back(a);
		requests_sent++;
		if (a.was_present)
			hits++;
		if (a.table_full)
			refusals++;
		if (r.mode == MODE_READ && !a.read_in_range)
			reads_out++;
	endtask

	// hold off new requests until every response is back
	task automatic settle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding", cycles,
				answers_due.size());
			$display("dedup_intern_table regression: fail");
			$finish;
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			if (!steady && $urandom_range(99) < IDLE_PCT) begin
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			responses_seen++;
			if (answers_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("response %0d arrived with no request outstanding", responses_seen);
			end else begin
				want = answers_due.pop_front();
				if (rsp.slot_index !== want.slot_index || rsp.was_present !== want.was_present ||
						rsp.table_full !== want.table_full ||
						rsp.read_value !== want.read_value ||
						rsp.read_in_range !== want.read_in_range) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch on response %0d", responses_seen);
						$display("  want slot=%0d present=%b full=%b value=%h in_range=%b",
							want.slot_index, want.was_present, want.table_full,
							want.read_value, want.read_in_range);
						$display("  got  slot=%0d present=%b full=%b value=%h in_range=%b",
							rsp.slot_index, rsp.was_present, rsp.table_full,
							rsp.read_value, rsp.read_in_range);
					end
				end
			end
		end
	end

	task automatic test_basic_modes();
		send_request(make_req(MODE_CLEAR, '1, 8'hff));
		send_request(make_req(MODE_READ, '0, 8'd0));
		send_request(make_req(MODE_INTERN, '0, 8'hff));
		send_request(make_req(MODE_INTERN, '1, 8'd0));
		send_request(make_req(MODE_INTERN, '0, 8'd0));
		send_request(make_req(MODE_INTERN, '1, 8'hff));
		send_request(make_req(MODE_READ, '1, 8'd0));
		send_request(make_req(MODE_READ, '0, 8'd1));
		send_request(make_req(MODE_READ, '0, 8'd2));
		send_request(make_req(MODE_READ, '1, 8'hff));
		send_request(make_req(MODE_UNUSED, '1, 8'hff));
		send_request(make_req(MODE_INTERN, 64'h8000_0000_0000_0001, 8'h55));
		send_request(make_req(MODE_READ, '0, 8'd2));
		settle();
	endtask

	task automatic test_full_table();
		logic [63:0] last_word;
		last_word = '0;
		send_request(make_req(MODE_CLEAR, '0, 8'd0));
		while (table_fill < TABLE_DEPTH) begin
			last_word = rand_word();
			send_request(make_req(MODE_INTERN, last_word, 8'haa));
		end
		send_request(make_req(MODE_INTERN, rand_word(), 8'd0));
		send_request(make_req(MODE_INTERN, last_word, 8'd0));
		send_request(make_req(MODE_READ, '0, 8'(TABLE_DEPTH - 1)));
		send_request(make_req(MODE_READ, '0, 8'(TABLE_DEPTH)));
		settle();
		send_request(make_req(MODE_CLEAR, rand_word(), 8'h0f));
		send_request(make_req(MODE_READ, '0, 8'd0));
		send_request(make_req(MODE_INTERN, last_word, 8'd0));
		send_request(make_req(MODE_READ, '0, 8'd0));
		settle();
	endtask

	// frames: mostly a clear, then interns from a small word pool mixed with reads and random-mode requests
	task automatic run_frames(int total);
		logic [63:0] pool [POOL_WORDS];
		int sent;
		int pool_size;
		int frame_len;
		int roll;
		sent = 0;
		while (sent < total) begin
			pool[0] = rand_word();
			for (int k = 1; k < POOL_WORDS; k++) begin
				if ($urandom_range(3) == 0)
					pool[k] = pool[k - 1] ^ (64'd1 << $urandom_range(63));
				else
					pool[k] = rand_word();
			end
			pool_size = $urandom_range(4, POOL_WORDS);
			frame_len = $urandom_range(4, 48);
			if ($urandom_range(4) != 0) begin
				send_request(make_req(MODE_CLEAR, rand_word(), 8'($urandom)));
				sent++;
			end
			for (int j = 0; j < frame_len; j++) begin
				roll = $urandom_range(99);
				if (roll < 55)
					send_request(make_req(MODE_INTERN, pool[$urandom_range(pool_size - 1)],
						8'($urandom)));
				else if (roll < 85)
					send_request(make_req(MODE_READ, rand_word(),
						8'($urandom_range(0, table_fill + 2))));
				else if (roll < 92)
					send_request(make_req(MODE_READ, rand_word(), 8'($urandom)));
				else
					send_request(make_req(2'($urandom), rand_word(), 8'($urandom)));
				sent++;
			end
			if ($urandom_range(9) == 0)
				settle();
		end
		settle();
	endtask

	task automatic test_random_frames();
		run_frames(1300);
	endtask

	task automatic test_back_to_back();
		steady = 1'b1;
		run_frames(400);
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		steady = 1'b0;
		table_fill = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_basic_modes();
		test_full_table();
		test_random_frames();
		test_back_to_back();

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d requests: %0d repeat hits, %0d refused interns,",
			requests_sent, hits, refusals);
		$display("  %0d out-of-range reads; checked %0d responses, %0d mismatches",
			reads_out, responses_seen, mismatches);
		if (mismatches == 0 && answers_due.size() == 0) begin
			$display("dedup_intern_table regression: pass");
		end else begin
			$display("dedup_intern_table regression: fail");
		end
		$finish;
	end

endmodule
